### rtl/text_grid_dirty_cell_renderer_macros.svh
// Assertion macros shared by the renderer checkers.
// Clock is clock, reset is reset; both must be visible where a macro is used.
`ifndef TEXT_GRID_DIRTY_CELL_RENDERER_MACROS_SVH
`define TEXT_GRID_DIRTY_CELL_RENDERER_MACROS_SVH

// same-cycle implication
`define TGR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tgr_pkg.sv
// Shared types and constants of the text grid renderer.
// No dependencies.
package tgr_pkg;

   localparam int DEF_GRID_COLS    = 20;
   localparam int DEF_GRID_ROWS    = 10;
   localparam int DEF_GLYPH_WIDTH  = 8;
   localparam int DEF_GLYPH_HEIGHT = 16;
   localparam int DEF_FIRST_CODE   = 32;
   localparam int DEF_GLYPH_COUNT  = 128;

   // widest cell index and font address over the parameter ranges
   localparam int CELL_IDX_W  = 12;
   localparam int FONT_ADDR_W = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIENTATION     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_COLOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHLIGHT_COLOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COLOR      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH_ENABLE  = 3'd4;

   localparam logic [1:0] ORIENT_0   = 2'd0;
   localparam logic [1:0] ORIENT_90  = 2'd1;
   localparam logic [1:0] ORIENT_180 = 2'd2;

   localparam logic [7:0] CMD_CASET = 8'h2A;
   localparam logic [7:0] CMD_RASET = 8'h2B;
   localparam logic [7:0] CMD_RAMWR = 8'h2C;
   localparam logic [7:0] SPACE_CODE = 8'h20;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FONT  = 2'd1,
      OP_START = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [CELL_IDX_W-1:0]  cell_idx;
      logic [7:0]             code;
      logic [15:0]            fore;
      logic [15:0]            back;
      logic [FONT_ADDR_W-1:0] font_addr;
      logic [7:0]             font_bits;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  orientation;
      logic [15:0] normal_color;
      logic [15:0] highlight_color;
      logic [15:0] back_color;
      logic        refresh_enable;
   } csr_type;

   typedef struct packed {
      logic [7:0]  code;
      logic [15:0] fore;
      logic [15:0] back;
   } cell_rec_type;

endpackage

### rtl/tgr_front.sv
// Front end: accepts request transfers, range-checks and classifies them,
// and holds them in a two-entry queue for the back end. Uses tgr_pkg.
module tgr_front #(
   parameter int GRID_COLS    = tgr_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS    = tgr_pkg::DEF_GRID_ROWS,
   parameter int GLYPH_HEIGHT = tgr_pkg::DEF_GLYPH_HEIGHT,
   parameter int FIRST_CODE   = tgr_pkg::DEF_FIRST_CODE,
   parameter int GLYPH_COUNT  = tgr_pkg::DEF_GLYPH_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [4:0]       req_cell_col,
   input  logic [3:0]       req_cell_row,
   input  logic [7:0]       req_char_code,
   input  logic             req_special,
   input  logic [3:0]       req_glyph_row,
   input  logic [7:0]       req_font_bits,
   input  tgr_pkg::csr_type csr,
   output logic             cmd_valid,
   output tgr_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import tgr_pkg::*;

   cmd_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   cmd_type    cls;
   logic       keep, push;

   always_comb begin
      cls           = '0;
      cls.op        = op_type'(req_mode);
      cls.code      = req_char_code;
      cls.font_bits = req_font_bits;
      cls.fore      = req_special ? csr.highlight_color : csr.normal_color;
      cls.back      = csr.back_color;
      cls.cell_idx  = CELL_IDX_W'(int'(req_cell_row) * GRID_COLS + int'(req_cell_col));
      cls.font_addr = FONT_ADDR_W'((int'(req_char_code) - FIRST_CODE) * GLYPH_HEIGHT
                                   + int'(req_glyph_row));
      case (op_type'(req_mode))
         OP_WRITE: begin
            keep = int'(req_cell_col) < GRID_COLS && int'(req_cell_row) < GRID_ROWS;
         end
         OP_FONT: begin
            keep = int'(req_char_code) >= FIRST_CODE
                   && int'(req_char_code) - FIRST_CODE < GLYPH_COUNT
                   && int'(req_glyph_row) < GLYPH_HEIGHT;
         end
         default: begin
            keep = 1'b1;
         end
      endcase
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall && keep;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (cmd_pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(cmd_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

### rtl/tgr_back.sv
// Back end: cell, shadow and font stores, dirty-run scanner and byte
// sequencer with the response register. Uses tgr_pkg.
module tgr_back #(
   parameter int GRID_COLS    = tgr_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS    = tgr_pkg::DEF_GRID_ROWS,
   parameter int GLYPH_WIDTH  = tgr_pkg::DEF_GLYPH_WIDTH,
   parameter int GLYPH_HEIGHT = tgr_pkg::DEF_GLYPH_HEIGHT,
   parameter int FIRST_CODE   = tgr_pkg::DEF_FIRST_CODE,
   parameter int GLYPH_COUNT  = tgr_pkg::DEF_GLYPH_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  tgr_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  tgr_pkg::csr_type csr,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_dc_flag,
   output logic [7:0]       rsp_spi_byte,
   output logic             rsp_pass_end
);
   import tgr_pkg::*;

   localparam int NCELLS     = GRID_COLS * GRID_ROWS;
   localparam int CIW        = NCELLS > 1 ? $clog2(NCELLS) : 1;
   localparam int MAXD       = GRID_COLS > GRID_ROWS ? GRID_COLS : GRID_ROWS;
   localparam int LW         = $clog2(MAXD + 1);
   localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int FAW        = FONT_DEPTH > 1 ? $clog2(FONT_DEPTH) : 1;
   localparam int GCW        = $clog2(GLYPH_HEIGHT);

   localparam logic [3:0] HDR_CASET  = 4'd0;
   localparam logic [3:0] HDR_XS     = 4'd2;
   localparam logic [3:0] HDR_XE     = 4'd4;
   localparam logic [3:0] HDR_RASET  = 4'd5;
   localparam logic [3:0] HDR_YS     = 4'd7;
   localparam logic [3:0] HDR_YE     = 4'd9;
   localparam logic [3:0] HDR_RAMWR  = 4'd10;

   localparam cell_rec_type BLANK_REC = '{code: SPACE_CODE, fore: 16'h0, back: 16'h0};

   typedef enum logic [3:0] {
      S_IDLE, S_FIND_RD, S_FIND_CMP, S_RUN_RD, S_RUN_CMP, S_DONE, S_NONE,
      S_PIX_RD, S_PIX_FONT, S_PIX_SEL, S_EMIT
   } state_type;

   cell_rec_type cell_mem  [NCELLS];
   cell_rec_type shown_mem [NCELLS];
   logic [7:0]   font_mem  [FONT_DEPTH];
   logic [NCELLS-1:0] cell_vld_ff, shown_vld_ff;
   cell_rec_type cell_q_ff, shown_q_ff, cell_cur, shown_cur;
   logic         cell_vq_ff, shown_vq_ff;
   logic [7:0]   font_q_ff;

   state_type state_ff;
   logic            busy_ff, from_tick_ff, in_pix_ff, half_ff;
   logic [1:0]      orient_ff;
   logic [LW-1:0]   k0_ff, line_ff, n_ff, wk_ff, wl_ff, j_ff;
   logic [3:0]      hdr_ff;
   logic [GCW-1:0]  u_ff, a_ff;
   logic            pend_dc_ff, pend_end_ff;
   logic [7:0]      pend_byte_ff;
   logic            rsp_valid_ff, rsp_dc_ff, rsp_end_ff;
   logic [7:0]      rsp_byte_ff;

   logic [CIW-1:0] rd_addr;
   logic [FAW-1:0] font_rd_addr;
   logic           changed, in_font, cell_we, shown_we, font_we, last_byte;
   logic           wrap, exhausted, font_bit;
   logic [LW-1:0]  len, lines, cand_k, cand_l, nxt_k, nxt_l;
   int             along, across, frow, fcol;
   logic           hdr_dc;
   logic [7:0]     hdr_byte;
   logic [15:0]    clr;

   function automatic logic [CIW-1:0] cell_at(input logic [1:0] o,
                                              input logic [LW-1:0] k,
                                              input logic [LW-1:0] ln);
      int cx, cy;
      case (o)
         ORIENT_0: begin
            cx = int'(k);
            cy = int'(ln);
         end
         ORIENT_90: begin
            cx = int'(ln);
            cy = GRID_ROWS - 1 - int'(k);
         end
         ORIENT_180: begin
            cx = GRID_COLS - 1 - int'(k);
            cy = GRID_ROWS - 1 - int'(ln);
         end
         default: begin
            cx = GRID_COLS - 1 - int'(ln);
            cy = int'(k);
         end
      endcase
      return CIW'(cy * GRID_COLS + cx);
   endfunction

   assign len    = orient_ff[0] ? LW'(GRID_ROWS) : LW'(GRID_COLS);
   assign lines  = orient_ff[0] ? LW'(GRID_COLS) : LW'(GRID_ROWS);
   assign along  = orient_ff[0] ? GLYPH_HEIGHT : GLYPH_WIDTH;
   assign across = orient_ff[0] ? GLYPH_WIDTH : GLYPH_HEIGHT;

   assign cell_cur  = cell_vq_ff ? cell_q_ff : BLANK_REC;
   assign shown_cur = shown_vq_ff ? shown_q_ff : BLANK_REC;
   assign changed   = cell_cur != shown_cur;

   always_comb begin
      if (state_ff == S_PIX_RD || state_ff == S_PIX_FONT || state_ff == S_PIX_SEL) begin
         rd_addr = cell_at(orient_ff, LW'(k0_ff + j_ff), line_ff);
      end else begin
         rd_addr = cell_at(orient_ff, wk_ff, wl_ff);
      end
   end

   // glyph coordinates of the current pixel
   always_comb begin
      case (orient_ff)
         ORIENT_0: begin
            frow = int'(a_ff);
            fcol = int'(u_ff);
         end
         ORIENT_90: begin
            fcol = int'(a_ff);
            frow = GLYPH_HEIGHT - 1 - int'(u_ff);
         end
         ORIENT_180: begin
            frow = GLYPH_HEIGHT - 1 - int'(a_ff);
            fcol = GLYPH_WIDTH - 1 - int'(u_ff);
         end
         default: begin
            fcol = GLYPH_WIDTH - 1 - int'(a_ff);
            frow = int'(u_ff);
         end
      endcase
   end

   assign in_font = int'(cell_cur.code) >= FIRST_CODE
                    && int'(cell_cur.code) - FIRST_CODE < GLYPH_COUNT;
   assign font_rd_addr = FAW'((int'(cell_cur.code) - FIRST_CODE) * GLYPH_HEIGHT + frow);
   assign font_bit = font_q_ff[3'(7 - fcol)];
   assign clr      = (in_font && font_bit) ? cell_cur.fore : cell_cur.back;

   always_comb begin
      hdr_dc   = 1'b1;
      hdr_byte = 8'h00;
      case (hdr_ff)
         HDR_CASET: begin
            hdr_dc   = 1'b0;
            hdr_byte = CMD_CASET;
         end
         HDR_XS:    hdr_byte = 8'(int'(k0_ff) * along);
         HDR_XE:    hdr_byte = 8'((int'(k0_ff) + int'(n_ff)) * along - 1);
         HDR_RASET: begin
            hdr_dc   = 1'b0;
            hdr_byte = CMD_RASET;
         end
         HDR_YS:    hdr_byte = 8'(int'(line_ff) * across);
         HDR_YE:    hdr_byte = 8'((int'(line_ff) + 1) * across - 1);
         HDR_RAMWR: begin
            hdr_dc   = 1'b0;
            hdr_byte = CMD_RAMWR;
         end
         default:   hdr_byte = 8'h00;
      endcase
   end

   assign last_byte = half_ff && u_ff == GCW'(along - 1) && j_ff == LW'(n_ff - 1'b1)
                      && a_ff == GCW'(across - 1);

   // next scan position after the current cell, or after the finished run
   assign cand_k    = (state_ff == S_PIX_SEL) ? LW'(k0_ff + n_ff) : LW'(wk_ff + 1'b1);
   assign cand_l    = (state_ff == S_PIX_SEL) ? line_ff : wl_ff;
   assign wrap      = cand_k == len;
   assign nxt_k     = wrap ? '0 : cand_k;
   assign nxt_l     = wrap ? LW'(cand_l + 1'b1) : cand_l;
   assign exhausted = wrap && cand_l == LW'(lines - 1'b1);

   assign cmd_pop  = state_ff == S_IDLE && cmd_valid;
   assign cell_we  = cmd_pop && cmd.op == OP_WRITE && !busy_ff;
   assign font_we  = cmd_pop && cmd.op == OP_FONT;
   assign shown_we = (state_ff == S_FIND_CMP || state_ff == S_RUN_CMP) && changed;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cmd.cell_idx[CIW-1:0]] <= '{code: cmd.code, fore: cmd.fore, back: cmd.back};
      end
      cell_q_ff <= cell_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (shown_we) begin
         shown_mem[rd_addr] <= cell_cur;
      end
      shown_q_ff <= shown_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (font_we) begin
         font_mem[cmd.font_addr[FAW-1:0]] <= cmd.font_bits;
      end
      font_q_ff <= font_mem[font_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff  <= '0;
         shown_vld_ff <= '0;
      end else begin
         if (cell_we) begin
            cell_vld_ff[cmd.cell_idx[CIW-1:0]] <= 1'b1;
         end
         if (shown_we) begin
            shown_vld_ff[rd_addr] <= 1'b1;
         end
      end
      cell_vq_ff  <= cell_vld_ff[rd_addr];
      shown_vq_ff <= shown_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  case (cmd.op)
                     OP_START: begin
                        if (!busy_ff && csr.refresh_enable) begin
                           orient_ff    <= csr.orientation;
                           wk_ff        <= '0;
                           wl_ff        <= '0;
                           from_tick_ff <= 1'b0;
                           state_ff     <= S_FIND_RD;
                        end
                     end
                     OP_TICK: begin
                        if (busy_ff && !in_pix_ff) begin
                           pend_dc_ff   <= hdr_dc;
                           pend_byte_ff <= hdr_byte;
                           pend_end_ff  <= 1'b0;
                           if (hdr_ff == HDR_RAMWR) begin
                              in_pix_ff <= 1'b1;
                              half_ff   <= 1'b0;
                              u_ff      <= '0;
                              j_ff      <= '0;
                              a_ff      <= '0;
                           end else begin
                              hdr_ff <= hdr_ff + 4'd1;
                           end
                           state_ff <= S_EMIT;
                        end else if (busy_ff) begin
                           state_ff <= S_PIX_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_FIND_RD: state_ff <= S_FIND_CMP;
            S_FIND_CMP: begin
               if (changed) begin
                  k0_ff   <= wk_ff;
                  line_ff <= wl_ff;
                  n_ff    <= LW'(1);
                  if (LW'(wk_ff + 1'b1) < len) begin
                     wk_ff    <= LW'(wk_ff + 1'b1);
                     state_ff <= S_RUN_RD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else if (exhausted) begin
                  state_ff <= S_NONE;
               end else begin
                  wk_ff    <= nxt_k;
                  wl_ff    <= nxt_l;
                  state_ff <= S_FIND_RD;
               end
            end
            S_RUN_RD: state_ff <= S_RUN_CMP;
            S_RUN_CMP: begin
               if (changed) begin
                  n_ff <= LW'(n_ff + 1'b1);
                  if (LW'(wk_ff + 1'b1) < len) begin
                     wk_ff    <= LW'(wk_ff + 1'b1);
                     state_ff <= S_RUN_RD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               busy_ff   <= 1'b1;
               hdr_ff    <= HDR_CASET;
               in_pix_ff <= 1'b0;
               state_ff  <= from_tick_ff ? S_EMIT : S_IDLE;
            end
            S_NONE: begin
               busy_ff     <= 1'b0;
               pend_end_ff <= 1'b1;
               state_ff    <= from_tick_ff ? S_EMIT : S_IDLE;
            end
            S_PIX_RD:   state_ff <= S_PIX_FONT;
            S_PIX_FONT: state_ff <= S_PIX_SEL;
            S_PIX_SEL: begin
               pend_dc_ff   <= 1'b1;
               pend_byte_ff <= half_ff ? clr[7:0] : clr[15:8];
               pend_end_ff  <= 1'b0;
               if (last_byte) begin
                  from_tick_ff <= 1'b1;
                  if (exhausted) begin
                     state_ff <= S_NONE;
                  end else begin
                     wk_ff    <= nxt_k;
                     wl_ff    <= nxt_l;
                     state_ff <= S_FIND_RD;
                  end
               end else begin
                  half_ff <= !half_ff;
                  if (half_ff) begin
                     if (u_ff == GCW'(along - 1)) begin
                        u_ff <= '0;
                        if (j_ff == LW'(n_ff - 1'b1)) begin
                           j_ff <= '0;
                           a_ff <= GCW'(a_ff + 1'b1);
                        end else begin
                           j_ff <= LW'(j_ff + 1'b1);
                        end
                     end else begin
                        u_ff <= GCW'(u_ff + 1'b1);
                     end
                  end
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dc_ff    <= pend_dc_ff;
                  rsp_byte_ff  <= pend_byte_ff;
                  rsp_end_ff   <= pend_end_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dc_flag  = rsp_dc_ff;
   assign rsp_spi_byte = rsp_byte_ff;
   assign rsp_pass_end = rsp_end_ff;

endmodule

### rtl/text_grid_dirty_cell_renderer.sv
// Text grid renderer top level: configuration registers, front end, back end.
// Write, font load and idle items are handled at pop; a header byte passes pop and
// response register, a pixel byte pop, cell read, font read, select, response register.
// A pass start or run end scans with a read and a compare step per examined cell, run cells
// included, then a final done step. Reset is synchronous: clears control state and cell valid bits, no clearing pass.
module text_grid_dirty_cell_renderer #(
   parameter int GRID_COLS    = tgr_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS    = tgr_pkg::DEF_GRID_ROWS,
   parameter int GLYPH_WIDTH  = tgr_pkg::DEF_GLYPH_WIDTH,
   parameter int GLYPH_HEIGHT = tgr_pkg::DEF_GLYPH_HEIGHT,
   parameter int FIRST_CODE   = tgr_pkg::DEF_FIRST_CODE,
   parameter int GLYPH_COUNT  = tgr_pkg::DEF_GLYPH_COUNT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_mode,
   input  logic [4:0]                       req_cell_col,
   input  logic [3:0]                       req_cell_row,
   input  logic [7:0]                       req_char_code,
   input  logic                             req_special,
   input  logic [3:0]                       req_glyph_row,
   input  logic [7:0]                       req_font_bits,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_dc_flag,
   output logic [7:0]                       rsp_spi_byte,
   output logic                             rsp_pass_end,
   input  logic                             csr_we,
   input  logic [tgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tgr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tgr_pkg::*;

   csr_type csr_ff;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{orientation: 2'd0, normal_color: 16'h0, highlight_color: 16'h0,
                     back_color: 16'h0, refresh_enable: 1'b1};
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIENTATION:     csr_ff.orientation     <= csr_wdata[1:0];
            CSR_NORMAL_COLOR:    csr_ff.normal_color    <= csr_wdata;
            CSR_HIGHLIGHT_COLOR: csr_ff.highlight_color <= csr_wdata;
            CSR_BACK_COLOR:      csr_ff.back_color      <= csr_wdata;
            CSR_REFRESH_ENABLE:  csr_ff.refresh_enable  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   tgr_front #(
      .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .GLYPH_HEIGHT(GLYPH_HEIGHT),
      .FIRST_CODE(FIRST_CODE), .GLYPH_COUNT(GLYPH_COUNT)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_cell_col(req_cell_col), .req_cell_row(req_cell_row),
      .req_char_code(req_char_code), .req_special(req_special),
      .req_glyph_row(req_glyph_row), .req_font_bits(req_font_bits),
      .csr(csr_ff), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
   );

   tgr_back #(
      .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .GLYPH_WIDTH(GLYPH_WIDTH),
      .GLYPH_HEIGHT(GLYPH_HEIGHT), .FIRST_CODE(FIRST_CODE), .GLYPH_COUNT(GLYPH_COUNT)
   ) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .csr(csr_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_dc_flag(rsp_dc_flag),
      .rsp_spi_byte(rsp_spi_byte), .rsp_pass_end(rsp_pass_end)
   );

endmodule

### rtl/tgr_checker.sv
// Port-level checker for the text grid renderer, bound to the top level.
// Uses tgr_pkg and the renderer assertion macros.
`include "text_grid_dirty_cell_renderer_macros.svh"
module tgr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_dc_flag,
   input logic [7:0] rsp_spi_byte,
   input logic       rsp_pass_end
);
   import tgr_pkg::*;

   `TGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid,
      "response dropped while stalled")
   `TGR_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
      $stable(rsp_spi_byte) && $stable(rsp_dc_flag) && $stable(rsp_pass_end),
      "stalled response changed")
   `TGR_ASSERT_NOW(a_end_is_pixel, rsp_valid && rsp_pass_end, rsp_dc_flag,
      "pass ended on a command byte")
   `TGR_ASSERT_NOW(a_cmd_code, rsp_valid && !rsp_dc_flag,
      rsp_spi_byte == CMD_CASET || rsp_spi_byte == CMD_RASET || rsp_spi_byte == CMD_RAMWR,
      "unknown command byte")

endmodule

bind text_grid_dirty_cell_renderer tgr_checker u_checker (.*);
